// ----- design/iamm_pkg.sv -----
// shared types and constants for the interval affine matrix multiply block
// request and result payload structs, operation codes, controller/datapath links
// no dependencies
package iamm_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int IDX_W       = 4;
  localparam int STEP_W      = 2;
  localparam int PROD_W      = 2 * DATA_W;
  // three full products plus a shifted translation, with headroom for the ceiling add
  localparam int SUM_W       = PROD_W + 2;
  localparam int ENTRY_COUNT = 12;
  localparam int CREDIT_W    = 2;

  localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

  localparam logic [STEP_W-1:0]   STEP_FIRST = 2'd0;
  localparam logic [STEP_W-1:0]   STEP_TRANS = 2'd3;
  localparam logic [IDX_W-1:0]    LAST_INDEX = 4'd11;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] lower_in;
    logic signed [DATA_W-1:0] upper_in;
  } iamm_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [DATA_W-1:0] lower_out;
    logic signed [DATA_W-1:0] upper_out;
    logic                     last;
  } iamm_out_t;

  // one memory read step of one result entry
  typedef struct packed {
    logic              issue;
    logic [IDX_W-1:0]  entry;
    logic [STEP_W-1:0] step;
  } iamm_cmd_t;

  typedef struct packed {
    logic out_taken;
  } iamm_status_t;

endpackage

// ----- design/iamm_ram.sv -----
// generic single write port, single read port memory with registered read
// no dependencies
module iamm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/iamm_ctrl.sv -----
// controller: accepts requests and sequences the four read steps of each result entry
// uses iamm_pkg; drives commands to iamm_dp and tracks results in flight
module iamm_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic [iamm_pkg::OP_W-1:0]    in_op,
  output logic                         in_stall,
  output iamm_pkg::iamm_cmd_t          cmd,
  input  iamm_pkg::iamm_status_t       status
);
  import iamm_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    entry_r, entry_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CREDIT_W-1:0] credit_r, credit_nxt;
  iamm_cmd_t           cmd_r, cmd_nxt;
  logic                issue;
  logic                start;

  always_comb begin
    state_nxt = state_r;
    entry_nxt = entry_r;
    step_nxt  = step_r;
    issue     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_op == OP_COMPUTE) begin
          state_nxt = S_RUN;
          entry_nxt = '0;
          step_nxt  = STEP_FIRST;
        end
      end
      S_RUN: begin
        // a new entry needs room downstream; later steps of an entry never wait
        if (step_r != STEP_FIRST || credit_r < CREDIT_MAX || status.out_taken) begin
          issue = 1'b1;
          if (step_r == STEP_TRANS) begin
            step_nxt = STEP_FIRST;
            if (entry_r == LAST_INDEX) begin
              state_nxt = S_IDLE;
            end else begin
              entry_nxt = entry_r + IDX_W'(1);
            end
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
    endcase
    start         = issue && step_r == STEP_FIRST;
    credit_nxt    = credit_r + CREDIT_W'(start) - CREDIT_W'(status.out_taken);
    cmd_nxt.issue = issue;
    cmd_nxt.entry = entry_r;
    cmd_nxt.step  = step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      entry_r  <= '0;
      step_r   <= STEP_FIRST;
      credit_r <= '0;
      cmd_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      entry_r  <= entry_nxt;
      step_r   <= step_nxt;
      credit_r <= credit_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

  assign in_stall = (state_r == S_RUN);
  assign cmd      = cmd_r;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CREDIT_MAX)
    else $error("more result entries in flight than downstream can hold");

  a_taken_needs_credit: assert property (@(posedge clk) disable iff (!rst_n)
    status.out_taken |-> credit_r != '0)
    else $error("result delivered with no entry in flight");

  a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.issue |-> $past(state_r == S_RUN))
    else $error("read step issued outside a compute");
`endif

endmodule

// ----- design/iamm_dp.sv -----
// datapath: matrix memories, interval products, min/max, accumulate, round and saturate
// uses iamm_pkg and iamm_ram; steered by iamm_ctrl commands
module iamm_dp #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_accept,
  input  iamm_pkg::iamm_in_t      in_data,
  input  iamm_pkg::iamm_cmd_t     cmd,
  output iamm_pkg::iamm_status_t  status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output iamm_pkg::iamm_out_t     out_data
);
  import iamm_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_ADD = (SUM_W'(1) <<< FRACTION_BITS) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_HI    = (SUM_W'(1) <<< (DATA_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO    = -(SUM_W'(1) <<< (DATA_W - 1));

  function automatic logic signed [PROD_W-1:0] min2(input logic signed [PROD_W-1:0] a,
                                                    input logic signed [PROD_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [PROD_W-1:0] max2(input logic signed [PROD_W-1:0] a,
                                                    input logic signed [PROD_W-1:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // load write, registered before it reaches the memories
  logic                ld_left_r, ld_left_nxt;
  logic                ld_right_r, ld_right_nxt;
  logic [IDX_W-1:0]    ld_addr_r;
  logic [PROD_W-1:0]   ld_data_r;
  logic                idx_ok;

  assign idx_ok       = in_data.entry_index < IDX_W'(ENTRY_COUNT);
  assign ld_left_nxt  = in_accept && idx_ok && in_data.operation == OP_LOAD_LEFT;
  assign ld_right_nxt = in_accept && idx_ok && in_data.operation == OP_LOAD_RIGHT;

  // memory read addresses: left row i column k (translation at column 3), right row k column j
  logic [IDX_W-1:0]  left_addr, right_addr;
  logic [PROD_W-1:0] left_rd, right_rd;

  assign left_addr  = {cmd.entry[3:2], cmd.step};
  assign right_addr = (cmd.step == STEP_TRANS) ? {2'b00, cmd.entry[1:0]}
                                                : {cmd.step, cmd.entry[1:0]};

  iamm_ram #(.WIDTH(PROD_W), .DEPTH(ENTRY_COUNT)) u_left_ram (
    .clk     (clk),
    .wr_en   (ld_left_r),
    .wr_addr (ld_addr_r),
    .wr_data (ld_data_r),
    .rd_en   (cmd.issue),
    .rd_addr (left_addr),
    .rd_data (left_rd)
  );

  iamm_ram #(.WIDTH(PROD_W), .DEPTH(ENTRY_COUNT)) u_right_ram (
    .clk     (clk),
    .wr_en   (ld_right_r),
    .wr_addr (ld_addr_r),
    .wr_data (ld_data_r),
    .rd_en   (cmd.issue),
    .rd_addr (right_addr),
    .rd_data (right_rd)
  );

  // pipeline tags
  iamm_cmd_t s1_r, s2_r, s3_r;

  // products
  logic signed [DATA_W-1:0] l_lo, l_hi, r_lo, r_hi;
  logic signed [PROD_W-1:0] prod_nxt [4];
  logic signed [PROD_W-1:0] prod_r [4];
  logic [PROD_W-1:0]        trans_r;

  assign l_lo = left_rd[DATA_W-1:0];
  assign l_hi = left_rd[PROD_W-1:DATA_W];
  assign r_lo = right_rd[DATA_W-1:0];
  assign r_hi = right_rd[PROD_W-1:DATA_W];

  always_comb begin
    prod_nxt[0] = l_lo * r_lo;
    prod_nxt[1] = l_lo * r_hi;
    prod_nxt[2] = l_hi * r_lo;
    prod_nxt[3] = l_hi * r_hi;
  end

  // min / max, or the translation scaled to product precision
  logic signed [DATA_W-1:0] t_lo, t_hi;
  logic signed [SUM_W-1:0]  mn_nxt, mx_nxt, mn_r, mx_r;

  assign t_lo = trans_r[DATA_W-1:0];
  assign t_hi = trans_r[PROD_W-1:DATA_W];

  always_comb begin
    if (s2_r.step == STEP_TRANS) begin
      // only the translation column picks up the left translation bound
      if (s2_r.entry[1:0] == 2'b11) begin
        mn_nxt = SUM_W'(t_lo) <<< FRACTION_BITS;
        mx_nxt = SUM_W'(t_hi) <<< FRACTION_BITS;
      end else begin
        mn_nxt = '0;
        mx_nxt = '0;
      end
    end else begin
      mn_nxt = SUM_W'(min2(min2(prod_r[0], prod_r[1]), min2(prod_r[2], prod_r[3])));
      mx_nxt = SUM_W'(max2(max2(prod_r[0], prod_r[1]), max2(prod_r[2], prod_r[3])));
    end
  end

  // exact accumulation
  logic signed [SUM_W-1:0] acc_lo_r, acc_hi_r, acc_lo_nxt, acc_hi_nxt;
  logic                    done_r, done_nxt;
  logic [IDX_W-1:0]        acc_idx_r;

  always_comb begin
    acc_lo_nxt = acc_lo_r;
    acc_hi_nxt = acc_hi_r;
    if (s3_r.issue) begin
      if (s3_r.step == STEP_FIRST) begin
        acc_lo_nxt = mn_r;
        acc_hi_nxt = mx_r;
      end else begin
        acc_lo_nxt = acc_lo_r + mn_r;
        acc_hi_nxt = acc_hi_r + mx_r;
      end
    end
  end

  assign done_nxt = s3_r.issue && s3_r.step == STEP_TRANS;

  // floor for the lower bound, ceiling for the upper, then clamp
  logic signed [SUM_W-1:0] lo_fl, hi_cl;
  iamm_out_t               res_r, res_nxt;
  logic                    res_valid_r, res_valid_nxt;
  iamm_out_t               out_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    res_move, out_taken;

  always_comb begin
    lo_fl                = acc_lo_r >>> FRACTION_BITS;
    hi_cl                = (acc_hi_r + ROUND_ADD) >>> FRACTION_BITS;
    res_nxt.result_index = acc_idx_r;
    res_nxt.lower_out    = sat(lo_fl);
    res_nxt.upper_out    = sat(hi_cl);
    res_nxt.last         = (acc_idx_r == LAST_INDEX);
  end

  // skid between the rounding stage and the output register
  assign out_taken     = out_valid_r && !out_stall;
  assign res_move      = res_valid_r && (!out_valid_r || !out_stall);
  assign res_valid_nxt = done_r || (res_valid_r && !res_move);
  assign out_valid_nxt = res_move || (out_valid_r && !out_taken);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_left_r   <= 1'b0;
      ld_right_r  <= 1'b0;
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      done_r      <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ld_left_r   <= ld_left_nxt;
      ld_right_r  <= ld_right_nxt;
      s1_r        <= cmd;
      s2_r        <= s1_r;
      s3_r        <= s2_r;
      done_r      <= done_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ld_addr_r <= in_data.entry_index;
    ld_data_r <= {in_data.upper_in, in_data.lower_in};
    prod_r    <= prod_nxt;
    trans_r   <= left_rd;
    mn_r      <= mn_nxt;
    mx_r      <= mx_nxt;
    acc_lo_r  <= acc_lo_nxt;
    acc_hi_r  <= acc_hi_nxt;
    acc_idx_r <= s3_r.entry;
    if (done_r) begin
      res_r <= res_nxt;
    end
    if (res_move) begin
      out_r <= res_r;
    end
  end

  assign status.out_taken = out_taken;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

`ifndef SYNTHESIS
  a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && res_valid_r |-> res_move)
    else $error("finished entry would overwrite a held result");

  a_steps_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    s3_r.issue && s3_r.step != STEP_FIRST |-> $past(s3_r.issue))
    else $error("accumulation step arrived without its predecessor");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !ld_left_r && !ld_right_r)
    else $error("matrix write collides with a compute read");
`endif

endmodule

// ----- design/interval_affine_matrix_multiply.sv -----
// interval affine matrix multiply, upper three rows of two homogeneous transforms
// each result entry reads 4 words (three k terms and the translation) from the matrix
// memories, and up to two entries are in flight, so the reads of a new entry can start
// before earlier results are taken; in_stall is high for the reads of a compute
// reset: synchronous, active low, clears control state; matrix entries are undefined until loaded
module interval_affine_matrix_multiply #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iamm_pkg::iamm_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iamm_pkg::iamm_out_t  out_data
);
  import iamm_pkg::*;

  logic         in_accept;
  iamm_cmd_t    cmd;
  iamm_status_t status;

  assign in_accept = in_valid && !in_stall;

  iamm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .status    (status)
  );

  iamm_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb_interval_affine_matrix_multiply.sv -----
`timescale 1ns / 1ps
// self-checking testbench for interval_affine_matrix_multiply (valid/stall on both channels)
// depends on iamm_pkg and the block; tracks both interval matrices and predicts each product
module tb_interval_affine_matrix_multiply;
  import iamm_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int CYCLE_LIMIT  = 300_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  // operation code the block must drop
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] Q16_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [79:0] WIDE_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] WIDE_MIN = -(80'sh8000_0000);
  localparam logic signed [79:0] ROUND_UP = (80'sd1 <<< FRAC_BITS) - 80'sd1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  iamm_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  iamm_out_t out_data;

  logic signed [DATA_W-1:0] left_lo  [ENTRY_COUNT];
  logic signed [DATA_W-1:0] left_hi  [ENTRY_COUNT];
  logic signed [DATA_W-1:0] right_lo [ENTRY_COUNT];
  logic signed [DATA_W-1:0] right_hi [ENTRY_COUNT];
  iamm_out_t product_entries_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_token = 1'b0;
  bit hold_seen = 1'b0;
  int cycle_count = 0;
  int error_count = 0;
  int requests_sent = 0;
  int computes_sent = 0;
  int entries_checked = 0;

  interval_affine_matrix_multiply #(.FRACTION_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall, or one long hold when the token flips
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_token;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic logic signed [DATA_W-1:0] clamp_q(input logic signed [79:0] v);
    if (v > WIDE_MAX) return Q16_MAX;
    if (v < WIDE_MIN) return Q16_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic iamm_in_t make_req(input logic [OP_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic signed [DATA_W-1:0] lo,
                                        input logic signed [DATA_W-1:0] hi);
    iamm_in_t r;
    r.operation   = op;
    r.entry_index = idx;
    r.lower_in    = lo;
    r.upper_in    = hi;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
      2: return Q16_MIN;
      3: return Q16_MAX;
      4: return $signed($urandom_range(0, 510)) - 32'sd255;
      default: return ($signed($urandom_range(0, 64)) - 32'sd32) <<< 16;
    endcase
  endfunction

  // loads update the matrices; a compute queues the 12 interval product entries
  task automatic compute_interval_product(input iamm_in_t req);
    int i, j, k, q, a, b;
    longint prods [4];
    longint lo_term, hi_term;
    logic signed [79:0] sum_lo, sum_hi, shift_t;
    iamm_out_t res;
    case (req.operation)
      OP_LOAD_LEFT: begin
        if (req.entry_index < ENTRY_COUNT) begin
          left_lo[req.entry_index] = req.lower_in;
          left_hi[req.entry_index] = req.upper_in;
        end
      end
      OP_LOAD_RIGHT: begin
        if (req.entry_index < ENTRY_COUNT) begin
          right_lo[req.entry_index] = req.lower_in;
          right_hi[req.entry_index] = req.upper_in;
        end
      end
      OP_COMPUTE: begin
        computes_sent++;
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 4; j++) begin
            sum_lo = '0;
            sum_hi = '0;
            for (k = 0; k < 3; k++) begin
              a = i * 4 + k;
              b = k * 4 + j;
              prods[0] = longint'(left_lo[a]) * longint'(right_lo[b]);
              prods[1] = longint'(left_lo[a]) * longint'(right_hi[b]);
              prods[2] = longint'(left_hi[a]) * longint'(right_lo[b]);
              prods[3] = longint'(left_hi[a]) * longint'(right_hi[b]);
              lo_term = prods[0];
              hi_term = prods[0];
              for (q = 1; q < 4; q++) begin
                if (prods[q] < lo_term) lo_term = prods[q];
                if (prods[q] > hi_term) hi_term = prods[q];
              end
              sum_lo = sum_lo + lo_term;
              sum_hi = sum_hi + hi_term;
            end
            if (j == 3) begin
              // translation column, aligned to the product scale
              shift_t = left_lo[i * 4 + 3];
              sum_lo = sum_lo + (shift_t <<< FRAC_BITS);
              shift_t = left_hi[i * 4 + 3];
              sum_hi = sum_hi + (shift_t <<< FRAC_BITS);
            end
            res.result_index = IDX_W'(i * 4 + j);
            res.lower_out    = clamp_q(sum_lo >>> FRAC_BITS);
            res.upper_out    = clamp_q((sum_hi + ROUND_UP) >>> FRAC_BITS);
            res.last         = (i * 4 + j == ENTRY_COUNT - 1);
            product_entries_due.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  // offer one request, optionally after an idle gap, and hold it until accepted
  task automatic send_request(input iamm_in_t req);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    compute_interval_product(req);
  endtask

  always @(posedge clk) begin
    iamm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      entries_checked++;
      if (product_entries_due.size() == 0) begin
        $error("result entry %0d arrived with nothing pending", out_data.result_index);
        error_count++;
      end else begin
        want = product_entries_due.pop_front();
        if (out_data.result_index !== want.result_index) begin
          $error("result_index: expected %0d, got %0d", want.result_index,
                 out_data.result_index);
          error_count++;
        end
        if (out_data.lower_out !== want.lower_out) begin
          $error("lower_out: expected %0d, got %0d", want.lower_out, out_data.lower_out);
          error_count++;
        end
        if (out_data.upper_out !== want.upper_out) begin
          $error("upper_out: expected %0d, got %0d", want.upper_out, out_data.upper_out);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  // every entry gets written before the first compute; small values exercise rounding
  task automatic test_fill_and_compute();
    int n;
    logic signed [DATA_W-1:0] lo, hi;
    for (n = 0; n < ENTRY_COUNT; n++) begin
      lo = -(n * 65536) - 1;
      hi = n * 65536 + 1;
      if (n == 5) send_request(make_req(OP_LOAD_LEFT, IDX_W'(n), hi, lo));
      else send_request(make_req(OP_LOAD_LEFT, IDX_W'(n), lo, hi));
      // entries above 6 come out reversed
      send_request(make_req(OP_LOAD_RIGHT, IDX_W'(n), n - 6, 7 - n));
    end
    send_request(make_req(OP_COMPUTE, IDX_W'(0), 32'sd0, 32'sd0));
  endtask

  // out-of-range loads and the unused code must leave the matrices alone
  task automatic test_ignored_requests();
    send_request(make_req(OP_LOAD_LEFT, IDX_W'(12), Q16_MAX, Q16_MIN));
    send_request(make_req(OP_LOAD_RIGHT, IDX_W'(15), Q16_MIN, Q16_MAX));
    send_request(make_req(OP_UNUSED, IDX_W'(3), $urandom, $urandom));
    send_request(make_req(OP_COMPUTE, IDX_W'($urandom_range(0, 15)), $urandom, $urandom));
  endtask

  // full-scale bounds drive the sums into both saturation limits
  task automatic test_saturation_extremes();
    int k;
    for (k = 0; k < 3; k++) begin
      send_request(make_req(OP_LOAD_LEFT, IDX_W'(k), Q16_MIN, Q16_MIN));
      send_request(make_req(OP_LOAD_RIGHT, IDX_W'(k * 4), Q16_MIN, Q16_MIN));
    end
    send_request(make_req(OP_LOAD_LEFT, IDX_W'(3), Q16_MIN, Q16_MAX));
    send_request(make_req(OP_LOAD_RIGHT, IDX_W'(1), Q16_MAX, Q16_MAX));
    send_request(make_req(OP_LOAD_RIGHT, IDX_W'(5), Q16_MAX, Q16_MAX));
    send_request(make_req(OP_LOAD_RIGHT, IDX_W'(9), Q16_MIN, Q16_MAX));
    send_request(make_req(OP_COMPUTE, IDX_W'(15), Q16_MIN, Q16_MAX));
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int n, sel;
    logic signed [DATA_W-1:0] lo, hi, tmp;
    logic [OP_W-1:0] op;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      lo = rand_bound();
      hi = rand_bound();
      // mostly well-ordered intervals, a few reversed
      if (lo > hi && $urandom_range(0, 9) != 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      op = $urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT;
      if (sel < 60) send_request(make_req(op, IDX_W'($urandom_range(0, 11)), lo, hi));
      else if (sel < 88)
        send_request(make_req(OP_COMPUTE, IDX_W'($urandom_range(0, 15)), lo, hi));
      else if (sel < 94) send_request(make_req(op, IDX_W'($urandom_range(12, 15)), lo, hi));
      else send_request(make_req(OP_UNUSED, IDX_W'($urandom_range(0, 15)), lo, hi));
    end
  endtask

  // long output hold while computes keep coming, so the block backs up to its input
  task automatic test_output_hold();
    int n;
    send_idle_pct = 0;
    hold_token <= ~hold_token;
    for (n = 0; n < 8; n++) begin
      send_request(make_req(OP_COMPUTE, IDX_W'($urandom_range(0, 15)), $urandom, $urandom));
      send_request(make_req(OP_LOAD_RIGHT, IDX_W'($urandom_range(0, 11)),
                            rand_bound(), rand_bound()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct <= 63;
    test_fill_and_compute();
    test_ignored_requests();
    test_saturation_extremes();
    test_random_traffic(110, 37, 63);
    test_random_traffic(110, 63, 37);
    test_output_hold();
    test_random_traffic(110, 0, 0);
    in_valid <= 1'b0;
    while (product_entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests sent (%0d computes), %0d product entries compared, %0d errors",
             requests_sent, computes_sent, entries_checked, error_count);
    $display("covered rounding, saturation, reversed and ignored requests, three idle mixes");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
